@@ rtl/core/spdp_pkg.sv @@
// Shared types and constants for the sparse vector dot product engine.
// Holds the command codes and the payload field types.
// Depends on nothing.
package spdp_pkg;

  localparam int unsigned IdxW   = 32;
  localparam int unsigned ValW   = 32;
  localparam int unsigned SumW   = 64;
  localparam int unsigned MatchW = 9;

  typedef logic [1:0]               cmd_t;
  typedef logic [IdxW-1:0]          idx_t;
  typedef logic signed [ValW-1:0]   val_t;
  typedef logic signed [SumW-1:0]   sum_t;
  typedef logic [MatchW-1:0]        match_t;

  // Command codes; the remaining code is ignored
  localparam cmd_t CMD_LOAD_FIRST  = 2'd0;
  localparam cmd_t CMD_LOAD_SECOND = 2'd1;
  localparam cmd_t CMD_COMPUTE     = 2'd2;

  localparam sum_t   SUM_MAX   = {1'b0, {(SumW-1){1'b1}}};
  localparam sum_t   SUM_MIN   = {1'b1, {(SumW-1){1'b0}}};
  localparam match_t MATCH_MAX = {MatchW{1'b1}};

endpackage

@@ rtl/core/sparse_dot_product.sv @@
// Sparse vector dot product engine: two element stores walked as a sorted merge.
// Loads leave busy_o low; busy_o is high through a compute's merge steps,
// where steps <= count_first + count_second, one merge step per store read.
// The result strobe done_o rises for one cycle at the end of a compute.
// rst_ni (async, active low) empties both vectors and clears both error flags;
// store contents are not cleared. The receiver cannot stall a result.
// Depends on spdp_pkg.
module sparse_dot_product #(
  parameter int unsigned CAPACITY = 256
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  spdp_pkg::cmd_t        command_i,
  input  spdp_pkg::idx_t        index_i,
  input  spdp_pkg::val_t        value_i,
  output logic                  done_o,
  output spdp_pkg::sum_t        dot_sum_o,
  output spdp_pkg::match_t      match_count_o,
  output logic                  order_error_o,
  output logic                  capacity_error_o,
  output logic                  saturated_o
);
  import spdp_pkg::*;

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned EW = IdxW + ValW;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_RUN    = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0]    state_q, state_d;
  logic [CW-1:0] cnt_a_q, cnt_b_q;
  logic [CW-1:0] a_q, a_d, b_q, b_d;
  idx_t          last_a_q, last_b_q;
  logic          order_q, cap_q;
  logic [EW-1:0] mem_a [CAPACITY];
  logic [EW-1:0] mem_b [CAPACITY];
  logic [EW-1:0] rd_a_q, rd_b_q;
  logic [AW-1:0] rd_addr_a, rd_addr_b;
  sum_t          prod_q, acc_q;
  logic          prod_vld_q, sat_q;
  match_t        match_q;
  logic          mul_en;
  logic          accept, start_compute;
  logic          load_a, load_b, wr_a, wr_b;
  idx_t          idx_a, idx_b;
  val_t          val_a, val_b;
  logic [SumW:0] sum_wide;
  logic          sum_ovf;

  assign accept        = start_i && !busy_o;
  assign start_compute = accept && (command_i == CMD_COMPUTE);
  assign load_a        = accept && (command_i == CMD_LOAD_FIRST);
  assign load_b        = accept && (command_i == CMD_LOAD_SECOND);

  // Drop loads into a full store or with a non-ascending index
  assign wr_a = load_a && (cnt_a_q < CW'(CAPACITY)) &&
                ((cnt_a_q == '0) || (index_i > last_a_q));
  assign wr_b = load_b && (cnt_b_q < CW'(CAPACITY)) &&
                ((cnt_b_q == '0) || (index_i > last_b_q));

  assign idx_a = rd_a_q[EW-1:ValW];
  assign idx_b = rd_b_q[EW-1:ValW];
  assign val_a = $signed(rd_a_q[ValW-1:0]);
  assign val_b = $signed(rd_b_q[ValW-1:0]);

  // Merge walk: advance the smaller head's cursor, both cursors on a match
  always_comb begin
    state_d = state_q;
    a_d     = a_q;
    b_d     = b_q;
    mul_en  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (start_compute) begin
          a_d     = '0;
          b_d     = '0;
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if ((a_q >= cnt_a_q) || (b_q >= cnt_b_q)) begin
          state_d = ST_FINISH;
        end else if (idx_a > idx_b) begin
          b_d = b_q + 1'b1;
        end else if (idx_a < idx_b) begin
          a_d = a_q + 1'b1;
        end else begin
          a_d    = a_q + 1'b1;
          b_d    = b_q + 1'b1;
          mul_en = 1'b1;
        end
      end
      ST_FINISH: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Read the entries the cursors will point at next cycle
  assign rd_addr_a = a_d[AW-1:0];
  assign rd_addr_b = b_d[AW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      a_q     <= '0;
      b_q     <= '0;
    end else begin
      state_q <= state_d;
      a_q     <= a_d;
      b_q     <= b_d;
    end
  end

  // Element stores: one write port for loads, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_a) begin
      mem_a[cnt_a_q[AW-1:0]] <= {index_i, value_i};
    end
    rd_a_q <= mem_a[rd_addr_a];
  end

  always_ff @(posedge clk_i) begin
    if (wr_b) begin
      mem_b[cnt_b_q[AW-1:0]] <= {index_i, value_i};
    end
    rd_b_q <= mem_b[rd_addr_b];
  end

  // Fill counts and error flags; clear both vectors when the result goes out
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_a_q <= '0;
      cnt_b_q <= '0;
      order_q <= 1'b0;
      cap_q   <= 1'b0;
    end else if (state_q == ST_FINISH) begin
      cnt_a_q <= '0;
      cnt_b_q <= '0;
      order_q <= 1'b0;
      cap_q   <= 1'b0;
    end else begin
      if (wr_a) cnt_a_q <= cnt_a_q + 1'b1;
      if (wr_b) cnt_b_q <= cnt_b_q + 1'b1;
      if ((load_a && (cnt_a_q >= CW'(CAPACITY))) ||
          (load_b && (cnt_b_q >= CW'(CAPACITY)))) begin
        cap_q <= 1'b1;
      end
      if ((load_a && (cnt_a_q < CW'(CAPACITY)) && !wr_a) ||
          (load_b && (cnt_b_q < CW'(CAPACITY)) && !wr_b)) begin
        order_q <= 1'b1;
      end
    end
  end

  // Hold the last stored index of each vector for the order check
  always_ff @(posedge clk_i) begin
    if (wr_a) last_a_q <= index_i;
    if (wr_b) last_b_q <= index_i;
  end

  // Multiply stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
    end else begin
      prod_vld_q <= mul_en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mul_en) prod_q <= sum_t'(val_a) * sum_t'(val_b);
  end

  // Saturating accumulate
  assign sum_wide = {acc_q[SumW-1], acc_q} + {prod_q[SumW-1], prod_q};
  assign sum_ovf  = sum_wide[SumW] != sum_wide[SumW-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sat_q   <= 1'b0;
      match_q <= '0;
    end else if (start_compute) begin
      sat_q   <= 1'b0;
      match_q <= '0;
    end else begin
      if (prod_vld_q && sum_ovf) sat_q <= 1'b1;
      if (mul_en && (match_q != MATCH_MAX)) match_q <= match_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_compute) begin
      acc_q <= '0;
    end else if (prod_vld_q) begin
      if (sum_ovf) begin
        acc_q <= sum_wide[SumW] ? SUM_MIN : SUM_MAX;
      end else begin
        acc_q <= sum_wide[SumW-1:0];
      end
    end
  end

  assign busy_o           = (state_q != ST_IDLE);
  assign done_o           = (state_q == ST_FINISH);
  assign dot_sum_o        = acc_q;
  assign match_count_o    = match_q;
  assign order_error_o    = order_q;
  assign capacity_error_o = cap_q;
  assign saturated_o      = sat_q;

  // Cursors never pass the fill counts during the walk
  a_cursor_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> ((a_q <= cnt_a_q) && (b_q <= cnt_b_q)))
    else $error("merge cursor beyond fill count");

  // Fill counts never exceed the store depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_a_q <= CW'(CAPACITY)) && (cnt_b_q <= CW'(CAPACITY)))
    else $error("fill count beyond capacity");

  // A result empties both vectors and returns to idle
  a_result_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> (!busy_o && (cnt_a_q == '0) && (cnt_b_q == '0)))
    else $error("vectors not cleared after result");

  // No product is left pending when the result goes out
  a_no_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !prod_vld_q)
    else $error("product pending at result");

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the sparse vector dot product engine.
// Drives loads and computes from a queue, predicts each result in-bench and
// checks every strobed result field by field. Depends on spdp_pkg and the RTL.
`timescale 1ns / 1ps

module tb_top;
  import spdp_pkg::*;

  localparam int unsigned CAP       = 256;
  localparam int unsigned NUM_ITEMS = 1350;
  localparam cmd_t        CMD_UNUSED = 2'd3;
  localparam val_t        VAL_MIN   = 32'sh8000_0000;
  localparam val_t        VAL_MAX   = 32'sh7fff_ffff;
  localparam idx_t        IDX_TOP   = 32'hffff_ffff;

  typedef struct {
    cmd_t        cmd;
    idx_t        idx;
    val_t        val;
    int unsigned gap;
    bit          drain;
  } op_item_t;

  typedef struct {
    sum_t   sum;
    match_t match_n;
    bit     ord;
    bit     cap;
    bit     sat;
  } dot_result_t;

  logic   clk_i   = 1'b0;
  logic   rst_ni  = 1'b0;
  logic   start_i = 1'b0;
  cmd_t   command_i = CMD_UNUSED;
  idx_t   index_i = '0;
  val_t   value_i = '0;
  logic   busy_o;
  logic   done_o;
  sum_t   dot_sum_o;
  match_t match_count_o;
  logic   order_error_o;
  logic   capacity_error_o;
  logic   saturated_o;

  sparse_dot_product #(
    .CAPACITY(CAP)
  ) DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .command_i       (command_i),
    .index_i         (index_i),
    .value_i         (value_i),
    .done_o          (done_o),
    .dot_sum_o       (dot_sum_o),
    .match_count_o   (match_count_o),
    .order_error_o   (order_error_o),
    .capacity_error_o(capacity_error_o),
    .saturated_o     (saturated_o)
  );

  // Shadow copy of both vectors and the sticky drop flags
  idx_t        vec_idx[2][CAP];
  val_t        vec_val[2][CAP];
  int unsigned vec_n[2];
  bit          order_seen;
  bit          full_seen;

  op_item_t    op_q[$];
  dot_result_t result_q[$];
  int unsigned errors;

  // Driver handshake state
  op_item_t    cur;
  bit          have_cur;
  bit          presenting;
  bit          took;
  int unsigned gap_left;

  // Stimulus shaping knobs
  bit          idle_on;
  bit          hold_next;

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  task automatic flag_mismatch(string field, logic [63:0] got, logic [63:0] want);
    $display("tb_top: mismatch on %s at %0t: got %h, expected %h", field, $realtime, got, want);
    errors++;
  endtask

  // Update the shadow vectors for one transfer; queue the sum for a compute
  task automatic apply_command(cmd_t cmd, idx_t idx, val_t val);
    int unsigned       v;
    int unsigned       n;
    int unsigned       a;
    int unsigned       b;
    longint            prod;
    logic signed [64:0] wide;
    dot_result_t       res;
    if (cmd == CMD_LOAD_FIRST || cmd == CMD_LOAD_SECOND) begin
      v = (cmd == CMD_LOAD_SECOND) ? 1 : 0;
      n = vec_n[v];
      if (n >= CAP) begin
        full_seen = 1'b1;
      end else if (n > 0 && idx <= vec_idx[v][n-1]) begin
        order_seen = 1'b1;
      end else begin
        vec_idx[v][n] = idx;
        vec_val[v][n] = val;
        vec_n[v] = n + 1;
      end
    end else if (cmd == CMD_COMPUTE) begin
      a = 0;
      b = 0;
      res.sum = '0;
      res.match_n = '0;
      res.sat = 1'b0;
      // Merge walk: advance the smaller index, accumulate on equal indices
      while (a < vec_n[0] && b < vec_n[1]) begin
        if (vec_idx[0][a] > vec_idx[1][b]) begin
          b++;
        end else if (vec_idx[0][a] < vec_idx[1][b]) begin
          a++;
        end else begin
          prod = longint'(vec_val[0][a]) * longint'(vec_val[1][b]);
          wide = $signed({res.sum[63], res.sum}) + $signed({prod[63], prod});
          if (wide[64] != wide[63]) begin
            res.sum = wide[64] ? SUM_MIN : SUM_MAX;
            res.sat = 1'b1;
          end else begin
            res.sum = wide[63:0];
          end
          if (res.match_n != MATCH_MAX) res.match_n++;
          a++;
          b++;
        end
      end
      res.ord = order_seen;
      res.cap = full_seen;
      result_q.insert(result_q.size(), res);
      vec_n[0] = 0;
      vec_n[1] = 0;
      order_seen = 1'b0;
      full_seen = 1'b0;
    end
  endtask

  // Check strobed results, then record the transfer taken at this edge
  always @(posedge clk_i) begin : monitor
    dot_result_t want;
    if (rst_ni) begin
      if (done_o) begin
        if (result_q.size() == 0) begin
          flag_mismatch("done_o (no compute pending)", 64'd1, 64'd0);
        end else begin
          want = result_q.pop_front();
          if (dot_sum_o !== want.sum) flag_mismatch("dot_sum", dot_sum_o, want.sum);
          if (match_count_o !== want.match_n)
            flag_mismatch("match_count", 64'(match_count_o), 64'(want.match_n));
          if (order_error_o !== want.ord)
            flag_mismatch("order_error", 64'(order_error_o), 64'(want.ord));
          if (capacity_error_o !== want.cap)
            flag_mismatch("capacity_error", 64'(capacity_error_o), 64'(want.cap));
          if (saturated_o !== want.sat)
            flag_mismatch("saturated", 64'(saturated_o), 64'(want.sat));
        end
      end
      if (start_i && !busy_o) begin
        apply_command(command_i, index_i, value_i);
        took = 1'b1;
      end
    end
  end

  // Present queued items after their idle gap; hold start until the transfer
  always @(negedge clk_i) begin : driver
    if (took) begin
      have_cur = 1'b0;
      presenting = 1'b0;
      took = 1'b0;
    end
    if (rst_ni && !have_cur && op_q.size() != 0 &&
        (!op_q[0].drain || result_q.size() == 0)) begin
      cur = op_q.pop_front();
      have_cur = 1'b1;
      gap_left = cur.gap;
    end
    if (have_cur && !presenting) begin
      if (gap_left == 0) presenting = 1'b1;
      else gap_left--;
    end
    start_i   <= presenting;
    command_i <= presenting ? cur.cmd : cmd_t'($urandom);
    index_i   <= presenting ? cur.idx : idx_t'($urandom);
    value_i   <= presenting ? cur.val : val_t'($urandom);
  end

  function automatic void push_op(cmd_t cmd, idx_t idx, val_t val);
    op_item_t it;
    it.cmd = cmd;
    it.idx = idx;
    it.val = val;
    it.gap = idle_on ? $urandom_range(0, 17) : 0;
    it.drain = hold_next;
    hold_next = 1'b0;
    op_q.insert(op_q.size(), it);
  endfunction

  // One vector pair with interleaved loads, ascending when clean, then a compute
  task automatic add_random_set(int unsigned n_first, int unsigned n_second, bit clean);
    idx_t        next_idx[2];
    int unsigned left[2];
    int unsigned v;
    idx_t        base;
    val_t        val;
    cmd_t        ld;
    bit          extreme;
    base = clean ? idx_t'($urandom_range(0, 1000)) : idx_t'($urandom);
    next_idx[0] = base + $urandom_range(0, 2);
    next_idx[1] = base + $urandom_range(0, 2);
    left[0] = n_first;
    left[1] = n_second;
    extreme = ($urandom_range(0, 4) == 0);
    while (left[0] + left[1] > 0) begin
      v = (left[1] == 0) ? 0 : (left[0] == 0) ? 1 : $urandom_range(0, 1);
      ld = (v == 1) ? CMD_LOAD_SECOND : CMD_LOAD_FIRST;
      if (extreme) val = $urandom_range(0, 1) ? VAL_MIN : VAL_MAX;
      else val = $urandom;
      if (!clean && $urandom_range(0, 39) == 0) begin
        // Stray index: usually breaks the ascending order
        push_op(ld, $urandom, val);
      end else if (!clean && $urandom_range(0, 39) == 0) begin
        // Index one below the next planned index of this vector
        push_op(ld, next_idx[v] - 1, val);
      end else begin
        push_op(ld, next_idx[v], val);
        next_idx[v] += $urandom_range(1, 3);
      end
      if (!clean && $urandom_range(0, 39) == 0) push_op(CMD_UNUSED, $urandom, $urandom);
      left[v]--;
    end
    push_op(CMD_COMPUTE, $urandom, $urandom);
  endtask

  initial begin : stimulus
    int unsigned set_no;
    int unsigned n_first;
    int unsigned n_second;

    // Empty vectors
    idle_on = 1'b0;
    push_op(CMD_COMPUTE, $urandom, $urandom);

    // Positive saturation, top index, both order drops, unused command
    push_op(CMD_LOAD_FIRST, 32'd0, VAL_MIN);
    push_op(CMD_LOAD_FIRST, 32'd1, VAL_MIN);
    push_op(CMD_LOAD_FIRST, IDX_TOP, VAL_MAX);
    push_op(CMD_LOAD_SECOND, 32'd0, VAL_MIN);
    push_op(CMD_LOAD_SECOND, 32'd1, VAL_MIN);
    push_op(CMD_LOAD_SECOND, IDX_TOP, 32'sd1);
    push_op(CMD_LOAD_FIRST, IDX_TOP, 32'sd5);
    push_op(CMD_LOAD_SECOND, 32'd0, 32'sd7);
    push_op(CMD_UNUSED, IDX_TOP, VAL_MAX);
    push_op(CMD_COMPUTE, $urandom, $urandom);

    // Negative saturation
    idle_on = 1'b1;
    push_op(CMD_LOAD_FIRST, 32'd7, VAL_MIN);
    push_op(CMD_LOAD_FIRST, 32'd8, VAL_MIN);
    push_op(CMD_LOAD_FIRST, 32'd9, VAL_MIN);
    push_op(CMD_LOAD_SECOND, 32'd7, VAL_MAX);
    push_op(CMD_LOAD_SECOND, 32'd8, VAL_MAX);
    push_op(CMD_LOAD_SECOND, 32'd9, VAL_MAX);
    push_op(CMD_COMPUTE, $urandom, $urandom);

    // Disjoint indices: no matches
    push_op(CMD_LOAD_FIRST, 32'd2, 32'sd1);
    push_op(CMD_LOAD_FIRST, 32'd4, -32'sd1);
    push_op(CMD_LOAD_SECOND, 32'd3, VAL_MAX);
    push_op(CMD_LOAD_SECOND, 32'd5, VAL_MIN);
    push_op(CMD_COMPUTE, $urandom, $urandom);

    // Random vector pairs; two of them overfill a store
    set_no = 0;
    while (op_q.size() < NUM_ITEMS) begin
      idle_on = ($urandom_range(0, 3) != 0);
      hold_next = (set_no == 0) || ($urandom_range(0, 5) == 0);
      n_first = $urandom_range(0, 12);
      n_second = $urandom_range(0, 12);
      if (set_no == 3) begin
        add_random_set(CAP + 2, $urandom_range(5, 40), 1'b1);
      end else if (set_no == 12) begin
        add_random_set($urandom_range(5, 40), CAP + 2, 1'b1);
      end else begin
        add_random_set(n_first, n_second, 1'b0);
      end
      set_no++;
    end

    // Release reset on a falling edge
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (op_q.size() != 0 || have_cur || result_q.size() != 0) @(posedge clk_i);
    repeat (600) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

endmodule
